// File: hw/rtl/ppiab_pkg.sv
package ppiab_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int COORD_BITS   = 16;

	localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
	localparam int IDX_W   = $clog2(MAX_VERTICES);
	localparam int FLY_W   = $clog2(3 * MAX_VERTICES + 1);
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int EPROD_W = 2 * DIFF_W;
	localparam int PROD_W  = 2 * COORD_BITS;
	localparam int AREA_W  = 40;
	localparam int SUM_W   = AREA_W + 1;
	localparam int WIDE_W  = (PROD_W + 2 > SUM_W + 1) ? PROD_W + 2 : SUM_W + 1;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic   operation;
		logic   restart;
		coord_t coord_x;
		coord_t coord_y;
	} in_t;

	typedef struct packed {
		logic              inside_res;
		logic [AREA_W-1:0] twice_area;
		coord_t            box_min_x;
		coord_t            box_max_x;
		coord_t            box_min_y;
		coord_t            box_max_y;
		logic [CNT_W-1:0]  stored_count;
		logic              dropped;
	} out_t;

	typedef struct packed {
		logic   valid;
		coord_t px;
		coord_t py;
		logic   odd;
	} tok_t;

	typedef struct packed {
		logic   restart;
		logic   add_open;
		coord_t ox;
		coord_t oy;
		coord_t lx;
		coord_t ly;
		coord_t fx;
		coord_t fy;
	} area_req_t;

endpackage

// File: hw/rtl/ppiab_cell.sv
module ppiab_cell import ppiab_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   active,
	input  logic   wr_en,
	input  coord_t wr_x,
	input  coord_t wr_y,
	input  coord_t nxt_x,
	input  coord_t nxt_y,
	input  tok_t   tok_in,
	output tok_t   tok_out,
	output coord_t vx,
	output coord_t vy
);

	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [EPROD_W-1:0] eprod_t;

	coord_t vx_q, vy_q;
	coord_t x0, y0, x1, y1;
	logic   span;
	diff_t  da, db, dc, dd;

	tok_t   tok_s1, tok_s2, tok_s3;
	logic   span_s1, span_s2;
	diff_t  da_s1, db_s1, dc_s1, dd_s1;
	eprod_t pl_s2, pr_s2;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			vx_q <= wr_x;
			vy_q <= wr_y;
		end
	end

	always_comb begin
		if (vx_q < nxt_x) begin
			x0 = vx_q;
			y0 = vy_q;
			x1 = nxt_x;
			y1 = nxt_y;
		end else begin
			x0 = nxt_x;
			y0 = nxt_y;
			x1 = vx_q;
			y1 = vy_q;
		end
		span = active && (x0 <= tok_in.px) && (tok_in.px < x1);
		da   = DIFF_W'(tok_in.px) - DIFF_W'(x0);
		db   = DIFF_W'(y1) - DIFF_W'(y0);
		dc   = DIFF_W'(tok_in.py) - DIFF_W'(y0);
		dd   = DIFF_W'(x1) - DIFF_W'(x0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
			tok_s3 <= '0;
		end else if (en) begin
			tok_s1 <= tok_in;
			tok_s2 <= tok_s1;
			tok_s3 <= '{valid: tok_s2.valid, px: tok_s2.px, py: tok_s2.py,
				odd: tok_s2.odd ^ (span_s2 && (pl_s2 > pr_s2))};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			span_s1 <= span;
			da_s1   <= da;
			db_s1   <= db;
			dc_s1   <= dc;
			dd_s1   <= dd;
			span_s2 <= span_s1;
			pl_s2   <= da_s1 * db_s1;
			pr_s2   <= dc_s1 * dd_s1;
		end
	end

	assign tok_out = tok_s3;
	assign vx      = vx_q;
	assign vy      = vy_q;

endmodule

// File: hw/rtl/ppiab_area.sv
module ppiab_area import ppiab_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  area_req_t         req,
	input  logic              take,
	output logic              busy,
	output logic              done,
	output logic [AREA_W-1:0] area
);

	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	localparam wide_t SUM_HI = {{(WIDE_W - SUM_W + 1){1'b0}}, {(SUM_W - 1){1'b1}}};
	localparam wide_t SUM_LO = {{(WIDE_W - SUM_W + 1){1'b1}}, {(SUM_W - 1){1'b0}}};

	function automatic sum_t sat_sum(input wide_t v);
		sum_t r;
		if (v > SUM_HI)
			r = SUM_HI[SUM_W-1:0];
		else if (v < SUM_LO)
			r = SUM_LO[SUM_W-1:0];
		else
			r = v[SUM_W-1:0];
		return r;
	endfunction

	logic  v_s1, v_s2, v_s3, v_s4;
	logic  add_s1, add_s2;
	prod_t pa_s1, pb_s1, pc_s1, pd_s1;
	sum_t  co_s2, cc_s2, cc_s3, total_s4;
	sum_t  sum_q;
	logic [SUM_W-1:0] mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			sum_q <= '0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3)
				v_s4 <= 1'b1;
			else if (take)
				v_s4 <= 1'b0;
			if (start && req.restart)
				sum_q <= '0;
			else if (v_s2 && add_s2)
				sum_q <= sat_sum(WIDE_W'(sum_q) + WIDE_W'(co_s2));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			add_s1 <= req.add_open;
			pa_s1  <= req.ox * req.ly;
			pb_s1  <= req.oy * req.lx;
			pc_s1  <= req.lx * req.fy;
			pd_s1  <= req.ly * req.fx;
		end
		add_s2   <= add_s1;
		co_s2    <= sat_sum(WIDE_W'(pa_s1) - WIDE_W'(pb_s1));
		cc_s2    <= sat_sum(WIDE_W'(pc_s1) - WIDE_W'(pd_s1));
		cc_s3    <= cc_s2;
		if (v_s3)
			total_s4 <= sat_sum(WIDE_W'(sum_q) + WIDE_W'(cc_s3));
	end

	always_comb begin
		mag = total_s4[SUM_W-1] ? SUM_W'(-total_s4) : SUM_W'(total_s4);
		if (mag > {1'b0, {AREA_W{1'b1}}})
			area = {AREA_W{1'b1}};
		else
			area = mag[AREA_W-1:0];
	end

	assign busy = v_s1 || v_s2 || v_s3 || v_s4;
	assign done = v_s4;

endmodule

// File: hw/rtl/polygon_point_in_area_bounds.sv
// channel | payload | handshake            | accepted when
// req     | in_t    | req_valid, req_stall | req_valid && !req_stall
// rsp     | out_t   | rsp_valid, rsp_stall | rsp_valid && !rsp_stall
//
// Queries stream one per cycle, unless a stalled rsp or a busy area unit holds them,
// through a chain of MAX_VERTICES edge cells, three stages each.
// An append waits until no query is in the chain and the area unit is idle; its result
// passes through partial cross products, cross sums, running sum, total and magnitude,
// and the next transaction is accepted only once the area unit has handed that result on.
// Reset clears count, area, box, drop flag and all valid bits; vertex cells are not cleared.
// A stall on rsp freezes the whole chain; the area unit holds its finished result.
module polygon_point_in_area_bounds import ppiab_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  in_t  req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output out_t rsp
);

	coord_t cell_x [MAX_VERTICES];
	coord_t cell_y [MAX_VERTICES];
	tok_t   tok    [MAX_VERTICES + 1];

	logic [CNT_W-1:0]  count_q, n_base;
	logic [FLY_W-1:0]  fly_q;
	logic [AREA_W-1:0] area_q, area_val;
	coord_t            min_x_q, max_x_q, min_y_q, max_y_q;
	coord_t            prev_x_q, prev_y_q;
	logic              dropped_q;
	logic              rsp_valid_q;
	out_t              rsp_q;

	logic      advance, is_query, fly_zero, q_acc, a_acc, store, exit_fire;
	logic      area_busy, area_done, area_take;
	area_req_t area_req;

	assign advance   = !rsp_valid_q || !rsp_stall;
	assign is_query  = (req.operation == OP_QUERY);
	assign fly_zero  = (fly_q == '0);
	assign req_stall = area_busy || (is_query ? !advance : !fly_zero);
	assign q_acc     = req_valid && !req_stall && is_query;
	assign a_acc     = req_valid && !req_stall && !is_query;
	assign n_base    = req.restart ? '0 : count_q;
	assign store     = (n_base < CNT_W'(MAX_VERTICES));
	assign exit_fire = tok[MAX_VERTICES].valid && advance;
	assign area_take = advance && !tok[MAX_VERTICES].valid && area_done;

	assign tok[0] = '{valid: q_acc, px: req.coord_x, py: req.coord_y, odd: 1'b0};

	for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
		coord_t nxt_x, nxt_y;
		if (k == MAX_VERTICES - 1) begin : g_last
			assign nxt_x = cell_x[0];
			assign nxt_y = cell_y[0];
		end else begin : g_mid
			assign nxt_x = (CNT_W'(k + 1) < count_q) ? cell_x[k+1] : cell_x[0];
			assign nxt_y = (CNT_W'(k + 1) < count_q) ? cell_y[k+1] : cell_y[0];
		end
		ppiab_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (advance),
			.active  (CNT_W'(k) < count_q),
			.wr_en   (a_acc && store && (n_base[IDX_W-1:0] == IDX_W'(k))),
			.wr_x    (req.coord_x),
			.wr_y    (req.coord_y),
			.nxt_x   (nxt_x),
			.nxt_y   (nxt_y),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1]),
			.vx      (cell_x[k]),
			.vy      (cell_y[k])
		);
	end

	always_comb begin
		area_req.restart  = req.restart;
		area_req.add_open = store && (n_base != '0);
		area_req.ox       = prev_x_q;
		area_req.oy       = prev_y_q;
		area_req.lx       = store ? req.coord_x : prev_x_q;
		area_req.ly       = store ? req.coord_y : prev_y_q;
		area_req.fx       = (store && n_base == '0) ? req.coord_x : cell_x[0];
		area_req.fy       = (store && n_base == '0) ? req.coord_y : cell_y[0];
	end

	ppiab_area u_area (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (a_acc),
		.req    (area_req),
		.take   (area_take),
		.busy   (area_busy),
		.done   (area_done),
		.area   (area_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			fly_q       <= '0;
			area_q      <= '0;
			min_x_q     <= '0;
			max_x_q     <= '0;
			min_y_q     <= '0;
			max_y_q     <= '0;
			dropped_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			case ({q_acc, exit_fire})
				2'b10:   fly_q <= fly_q + FLY_W'(1);
				2'b01:   fly_q <= fly_q - FLY_W'(1);
				default: fly_q <= fly_q;
			endcase
			if (a_acc) begin
				if (req.restart)
					dropped_q <= 1'b0;
				if (!store) begin
					dropped_q <= 1'b1;
				end else begin
					count_q <= n_base + CNT_W'(1);
					if (n_base == '0) begin
						min_x_q <= req.coord_x;
						max_x_q <= req.coord_x;
						min_y_q <= req.coord_y;
						max_y_q <= req.coord_y;
					end else begin
						if (req.coord_x < min_x_q)
							min_x_q <= req.coord_x;
						if (req.coord_x > max_x_q)
							max_x_q <= req.coord_x;
						if (req.coord_y < min_y_q)
							min_y_q <= req.coord_y;
						if (req.coord_y > max_y_q)
							max_y_q <= req.coord_y;
					end
				end
			end
			if (area_take)
				area_q <= area_val;
			if (advance)
				rsp_valid_q <= tok[MAX_VERTICES].valid || area_done;
		end
	end

	always_ff @(posedge clk) begin
		if (a_acc && store) begin
			prev_x_q <= req.coord_x;
			prev_y_q <= req.coord_y;
		end
		if (advance) begin
			rsp_q.box_min_x    <= min_x_q;
			rsp_q.box_max_x    <= max_x_q;
			rsp_q.box_min_y    <= min_y_q;
			rsp_q.box_max_y    <= max_y_q;
			rsp_q.stored_count <= count_q;
			rsp_q.dropped      <= dropped_q;
			if (tok[MAX_VERTICES].valid) begin
				rsp_q.inside_res <= tok[MAX_VERTICES].odd;
				rsp_q.twice_area <= area_q;
			end else begin
				rsp_q.inside_res <= 1'b0;
				rsp_q.twice_area <= area_val;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: hw/rtl/ppiab_chk.sv
module ppiab_chk import ppiab_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input in_t  req,
	input logic rsp_valid,
	input logic rsp_stall,
	input out_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp transaction changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.stored_count == '0 |->
			rsp.twice_area == '0 && !rsp.inside_res &&
			rsp.box_min_x == '0 && rsp.box_max_x == '0 &&
			rsp.box_min_y == '0 && rsp.box_max_y == '0)
		else $error("empty polygon reports nonzero area, box or inside");

	a_inside_needs_area: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.inside_res |-> rsp.stored_count >= CNT_W'(3))
		else $error("inside reported for fewer than three vertices");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.dropped |-> rsp.stored_count == CNT_W'(MAX_VERTICES))
		else $error("drop flag set while store not full");

	a_query_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.operation == OP_QUERY |-> !(rsp_valid && rsp_stall))
		else $error("query transaction taken while output held");

endmodule

bind polygon_point_in_area_bounds ppiab_chk u_ppiab_chk (.*);
